// File: sv/assert_macros.svh
// Assertion helpers used by the top-level RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg)

`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

// File: sv/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Ratio and step registers are unsigned Q3.16.
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W    = 16;

    localparam logic [CFG_W-1:0] ONE_Q16  = CFG_W'(32'h10000);
    localparam logic [CFG_W-1:0] HALF_Q16 = CFG_W'(32'h08000);

    // Results produced by a single input beat are capped.
    localparam int MAX_RES = 10;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [CFG_IDX_W-1:0] REG_RATIO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [CFG_W-1:0] ratio_q16;
        logic [CFG_W-1:0] step_q16;   // effective step, forced to 1.0 at unit ratio
    } lir_cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } lir_q_stat_t;

    // Queue entry: {total, k, last, b, a}, a in the lowest bits.
    function automatic int item_width(int sw, int cw);
        return 2 * sw + 1 + cw + cw + 2;
    endfunction

endpackage

// File: sv/linear_interp_resampler.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Linear interpolation resampler for one buffer of signed samples at a time.
// Each input beat is queued by the front end, which also works out the total
// output count for a buffer that would end on it; the back end then produces
// that input's results one per cycle, unless the output stalls, from a Q.16
// read position that advances by the step register. An input yields at most
// ten results, on average about ratio of them: about four for a ratio of 4.0.
// The two-entry queue lets the input side keep accepting while results wait.
// Write ratio (index 0) and step (index 1, normally 1/ratio) only while idle.
// A ratio of exactly 1.0 copies the stream unchanged. After the beat marked
// tlast, held copies of it and then zeros pad the buffer out to
// round(n * ratio) results, and the block is ready for the next buffer.
module linear_interp_resampler import lir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // sample, zero padded above
    input  logic                 s_tlast,   // last sample of the buffer
    // Output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // out_sample, zero padded above
    output logic                 m_tlast,   // buffer_last
    output logic                 m_tuser,   // run_last
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ITEM_W = item_width(SAMPLE_WIDTH, COUNT_WIDTH);

    lir_cfg_t                cfg;
    lir_q_stat_t             q_stat;
    logic                    q_push;
    logic                    q_pop;
    logic [ITEM_W-1:0]       q_in;
    logic [ITEM_W-1:0]       q_head;
    logic [SAMPLE_WIDTH-1:0] out_sample;

    lir_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lir_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_WIDTH-1:0]),
        .in_last   (s_tlast),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    lir_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head_data (q_head),
        .stat      (q_stat)
    );

    lir_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_stat        (q_stat),
        .q_data        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_sample      (out_sample),
        .m_run_last    (m_tuser),
        .m_buffer_last (m_tlast)
    );

    assign m_tdata = DATA_W'(out_sample);

    `ASSERT_IMPLIES(a_pop_has_item, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `ASSERT_NEVER(a_queue_flags, clk, rst_n, q_stat.empty && q_stat.full, "queue empty and full")
    `ASSERT_IMPLIES(a_buf_ends_run, clk, rst_n, m_tvalid && m_tlast, m_tuser, "buffer end without run end")

endmodule

// File: sv/lir_cfg.sv
`timescale 1ns / 1ps

module lir_cfg import lir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output lir_cfg_t             cfg
);

    logic [CFG_W-1:0] ratio_reg;
    logic [CFG_W-1:0] ratio_next;
    logic [CFG_W-1:0] step_reg;
    logic [CFG_W-1:0] step_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        ratio_next = ratio_reg;
        step_next  = step_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RATIO: ratio_next = cfg_data;
                REG_STEP:  step_next  = cfg_data;
                default:
                begin
                    ratio_next = ratio_reg;
                    step_next  = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= ONE_Q16;
            step_reg  <= ONE_Q16;
        end
        else
        begin
            ratio_reg <= ratio_next;
            step_reg  <= step_next;
        end
    end

    // A unit ratio always steps by exactly one input so the stream is copied.
    assign cfg.ratio_q16 = ratio_reg;
    assign cfg.step_q16  = (ratio_reg == ONE_Q16) ? ONE_Q16 : step_reg;

endmodule

// File: sv/lir_fifo.sv
`timescale 1ns / 1ps

module lir_fifo import lir_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output lir_q_stat_t      stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/lir_front.sv
`timescale 1ns / 1ps

module lir_front import lir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lir_cfg_t                cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] in_sample,
    input  logic                    in_last,
    input  lir_q_stat_t             q_stat,
    output logic                    q_push,
    output logic [item_width(SAMPLE_WIDTH, COUNT_WIDTH)-1:0] q_data
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int OC_W   = CW + 2;
    localparam int PROD_W = CW + 1 + CFG_W;

    logic [SW-1:0]     prev_reg;
    logic [SW-1:0]     prev_next;
    logic [CW-1:0]     ic_reg;
    logic [CW-1:0]     ic_next;
    logic              accept;
    logic [CW:0]       kp1;
    logic [PROD_W-1:0] prod;
    logic [PROD_W:0]   rounded;
    logic [OC_W-1:0]   total;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    // Output count for a buffer ending here: round((k + 1) * ratio), saturated.
    assign kp1     = {1'b0, ic_reg} + 1'b1;
    assign prod    = PROD_W'(kp1) * PROD_W'(cfg.ratio_q16);
    assign rounded = {1'b0, prod} + (PROD_W + 1)'(HALF_Q16);
    assign total   = (|rounded[PROD_W:FRAC_W + OC_W]) ? '1 : rounded[FRAC_W + OC_W - 1:FRAC_W];

    assign q_data = {total, ic_reg, in_last, in_sample, prev_reg};

    always_comb
    begin
        prev_next = prev_reg;
        ic_next   = ic_reg;
        if (accept)
        begin
            if (in_last)
            begin
                prev_next = '0;
                ic_next   = '0;
            end
            else
            begin
                prev_next = in_sample;
                ic_next   = ic_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            ic_reg   <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
            ic_reg   <= ic_next;
        end
    end

endmodule

// File: sv/lir_back.sv
`timescale 1ns / 1ps

module lir_back import lir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lir_cfg_t                cfg,
    input  lir_q_stat_t             q_stat,
    input  logic [item_width(SAMPLE_WIDTH, COUNT_WIDTH)-1:0] q_data,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SAMPLE_WIDTH-1:0] m_sample,
    output logic                    m_run_last,
    output logic                    m_buffer_last
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int OC_W   = CW + 2;
    localparam int RP_W   = CW + 18;
    localparam int ITEM_W = item_width(SW, CW);
    localparam int ACC_W  = SW + 19;
    localparam logic [RES_CNT_W-1:0] RES_CAP = RES_CNT_W'(MAX_RES);

    // Head entry fields.
    logic [SW-1:0]   a;
    logic [SW-1:0]   b;
    logic            last;
    logic [CW-1:0]   k;
    logic [OC_W-1:0] total;

    logic [RP_W-1:0]      rp_reg;
    logic [RP_W-1:0]      rp_next;
    logic [OC_W-1:0]      oc_reg;
    logic [OC_W-1:0]      oc_next;
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] cnt_next;
    logic                 hold_reg;
    logic                 hold_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [SW-1:0]        sample_reg;
    logic [SW-1:0]        sample_next;
    logic                 run_last_reg;
    logic                 run_last_next;
    logic                 buf_last_reg;
    logic                 buf_last_next;

    logic [OC_W-1:0]      rp_int;
    logic [OC_W-1:0]      n_rp_int;
    logic [OC_W-1:0]      k_ext;
    logic [OC_W-1:0]      kp1_ext;
    logic [OC_W-1:0]      km1_ext;
    logic [RP_W-1:0]      nrp;
    logic [OC_W-1:0]      noc;
    logic [RES_CNT_W-1:0] ncnt;
    logic                 cnt_ok;
    logic                 lim_ok;
    logic                 tot_ok;
    logic                 do_interp;
    logic                 do_hold;
    logic                 emit;
    logic                 more;
    logic                 go;
    logic                 finish;

    logic [FRAC_W-1:0]       frac;
    logic signed [SW:0]      diff;
    logic signed [SW+17:0]   prod;
    logic [ACC_W-1:0]        acc;
    logic [SW-1:0]           lerp_val;
    logic [SW-1:0]           held_val;

    assign a     = q_data[SW-1:0];
    assign b     = q_data[2*SW-1:SW];
    assign last  = q_data[2*SW];
    assign k     = q_data[2*SW+CW:2*SW+1];
    assign total = q_data[ITEM_W-1:2*SW+CW+1];

    // Positions are compared by their integer part against the input index.
    assign rp_int  = rp_reg[RP_W-1:FRAC_W];
    assign k_ext   = OC_W'(k);
    assign kp1_ext = k_ext + 1'b1;
    assign km1_ext = k_ext - 1'b1;

    assign cnt_ok = (cnt_reg < RES_CAP);
    assign lim_ok = (rp_int < k_ext);
    assign tot_ok = (oc_reg < total);

    // Once the held/zero tail has started, interpolation does not resume.
    assign do_interp = !hold_reg && cnt_ok && lim_ok && (!last || tot_ok);
    assign do_hold   = !do_interp && last && cnt_ok && tot_ok;
    assign emit      = do_interp || do_hold;

    assign nrp      = rp_reg + RP_W'(cfg.step_q16);
    assign noc      = oc_reg + 1'b1;
    assign ncnt     = cnt_reg + 1'b1;
    assign n_rp_int = nrp[RP_W-1:FRAC_W];

    // Look one result ahead so the current one can carry the end-of-run flag.
    assign more = (ncnt < RES_CAP) &&
                  ((do_interp && (n_rp_int < k_ext) && (!last || (noc < total))) ||
                   (last && (noc < total)));

    assign go     = !q_stat.empty && (!valid_reg || m_ready);
    assign finish = go && (!emit || !more);
    assign q_pop  = finish;

    // A position left behind by the result cap interpolates with zero fraction.
    assign frac     = (rp_int >= km1_ext) ? rp_reg[FRAC_W-1:0] : '0;
    assign diff     = $signed({b[SW-1], b}) - $signed({a[SW-1], a});
    assign prod     = $signed({1'b0, frac}) * diff;
    assign acc      = ACC_W'(prod) + {{3{a[SW-1]}}, a, {FRAC_W{1'b0}}} + ACC_W'(HALF_Q16);
    assign lerp_val = acc[SW+FRAC_W-1:FRAC_W];
    assign held_val = (rp_int < kp1_ext) ? b : '0;

    always_comb
    begin
        valid_next    = valid_reg;
        sample_next   = sample_reg;
        run_last_next = run_last_reg;
        buf_last_next = buf_last_reg;
        if (valid_reg && m_ready)
        begin
            valid_next = 1'b0;
        end
        if (go && emit)
        begin
            valid_next    = 1'b1;
            sample_next   = do_interp ? lerp_val : held_val;
            run_last_next = !more;
            buf_last_next = !more && last;
        end
    end

    always_comb
    begin
        rp_next   = rp_reg;
        oc_next   = oc_reg;
        cnt_next  = cnt_reg;
        hold_next = hold_reg;
        if (go && emit)
        begin
            rp_next   = nrp;
            oc_next   = noc;
            cnt_next  = ncnt;
            hold_next = do_hold;
        end
        if (finish)
        begin
            cnt_next  = '0;
            hold_next = 1'b0;
            if (last)
            begin
                rp_next = '0;
                oc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg       <= '0;
            oc_reg       <= '0;
            cnt_reg      <= '0;
            hold_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            run_last_reg <= 1'b0;
            buf_last_reg <= 1'b0;
        end
        else
        begin
            rp_reg       <= rp_next;
            oc_reg       <= oc_next;
            cnt_reg      <= cnt_next;
            hold_reg     <= hold_next;
            valid_reg    <= valid_next;
            run_last_reg <= run_last_next;
            buf_last_reg <= buf_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign m_valid       = valid_reg;
    assign m_sample      = sample_reg;
    assign m_run_last    = run_last_reg;
    assign m_buffer_last = buf_last_reg;

endmodule

// File: verif/linear_interp_resampler_tb.sv
`timescale 1ns / 1ps

module linear_interp_resampler_tb;
    import lir_pkg::*;

    localparam int          PHASE_ITEMS  = 16;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_LIMIT  = 4000;
    localparam logic [63:0] OUT_CNT_MAX  = 64'h3FF_FFFF;

    typedef struct packed {
        logic [15:0] smp;
        logic        run_last;
        logic        buf_last;
    } out_beat_t;

    // Tracks the resampler state and holds the output beats still owed.
    class resample_scoreboard;
        logic [CFG_W-1:0] ratio_reg;
        logic [CFG_W-1:0] step_reg;
        logic [15:0]      prev;
        logic [23:0]      in_count;
        logic [25:0]      out_count;
        logic [41:0]      rd_pos;
        out_beat_t        owed_q[$];
        int               errors;
        int               inputs;
        int               results;
        int               buffers;
        int               writes;

        function new();
            ratio_reg = ONE_Q16;
            step_reg  = ONE_Q16;
            prev      = '0;
            in_count  = '0;
            out_count = '0;
            rd_pos    = '0;
            errors    = 0;
            inputs    = 0;
            results   = 0;
            buffers   = 0;
            writes    = 0;
        endfunction

        function void note_failure(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            writes++;
            if (idx == REG_RATIO)
                ratio_reg = val;
            else if (idx == REG_STEP)
                step_reg = val;
        endfunction

        function void note_input(logic [15:0] smp, logic is_last);
            logic signed [15:0] a;
            logic signed [15:0] b;
            logic [23:0]        k;
            logic [CFG_W-1:0]   eff_step;
            logic [63:0]        limit;
            logic [63:0]        base;
            logic [63:0]        total;
            logic [63:0]        end_pos;
            logic [63:0]        frac;
            longint             acc;
            int                 cnt;
            out_beat_t          beats[MAX_RES];

            inputs++;
            a        = prev;
            b        = smp;
            k        = in_count;
            eff_step = (ratio_reg == ONE_Q16) ? ONE_Q16 : step_reg;
            limit    = 64'(k) << 16;
            base     = (k == 0) ? 64'd0 : (64'(k) - 64'd1) << 16;
            total    = 64'd0;
            cnt      = 0;
            if (is_last)
            begin
                total = ((64'(k) + 64'd1) * 64'(ratio_reg) + 64'd32768) >> 16;
                if (total > OUT_CNT_MAX)
                    total = OUT_CNT_MAX;
            end

            // Interpolated outputs whose position falls between the two samples.
            while (cnt < MAX_RES && 64'(rd_pos) < limit &&
                   (!is_last || 64'(out_count) < total))
            begin
                frac = (64'(rd_pos) >= base) ? 64'(rd_pos) - base : 64'd0;
                acc  = longint'(a) * 65536 + longint'(frac[15:0]) *
                       (longint'(b) - longint'(a)) + 32768;
                acc  = acc >>> 16;
                beats[cnt].smp      = acc[15:0];
                beats[cnt].run_last = 1'b0;
                beats[cnt].buf_last = 1'b0;
                cnt++;
                rd_pos    = rd_pos + 42'(eff_step);
                out_count = out_count + 26'd1;
            end

            if (is_last)
            begin
                // Pad with held copies of the final sample, then zeros.
                end_pos = (64'(k) + 64'd1) << 16;
                while (cnt < MAX_RES && 64'(out_count) < total)
                begin
                    beats[cnt].smp      = (64'(rd_pos) < end_pos) ? b : 16'd0;
                    beats[cnt].run_last = 1'b0;
                    beats[cnt].buf_last = 1'b0;
                    cnt++;
                    rd_pos    = rd_pos + 42'(eff_step);
                    out_count = out_count + 26'd1;
                end
                if (cnt > 0)
                begin
                    beats[cnt-1].run_last = 1'b1;
                    beats[cnt-1].buf_last = 1'b1;
                end
                prev      = '0;
                in_count  = '0;
                out_count = '0;
                rd_pos    = '0;
                buffers++;
            end
            else
            begin
                if (cnt > 0)
                    beats[cnt-1].run_last = 1'b1;
                prev     = b;
                in_count = k + 24'd1;
            end

            for (int i = 0; i < cnt; i++)
                owed_q.insert(owed_q.size(), beats[i]);
        endfunction

        function void check_result(logic [15:0] smp, logic run_last, logic buf_last);
            out_beat_t want;
            results++;
            if (owed_q.size() == 0)
            begin
                note_failure($sformatf("unexpected beat: sample %h run_last %b buffer_last %b",
                                       smp, run_last, buf_last));
                return;
            end
            want = owed_q.pop_front();
            if (want.smp !== smp || want.run_last !== run_last || want.buf_last !== buf_last)
                note_failure($sformatf({"beat %0d: expected sample %h run_last %b ",
                                        "buffer_last %b, got %h %b %b"},
                                       results, want.smp, want.run_last, want.buf_last,
                                       smp, run_last, buf_last));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    resample_scoreboard sb;
    int                 send_idle_pct;
    int                 stall_pct;
    int                 hold_reqs;
    int                 quiet_cycles = 0;

    linear_interp_resampler dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Input beats are noted before output beats are checked at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("linear_interp_resampler: mismatch");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_seen;
        int hold_left;
        m_tready  = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end
            else if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES - 1;
                m_tready  = 1'b0;
            end
            else
                m_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Entered and left at a falling edge; tvalid stays high between back-to-back beats.
    // Each cycle is left idle with the chosen probability before the beat is offered.
    task automatic send_sample(input logic [15:0] smp, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tlast  = is_last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        // Inputs that produce nothing may still be in the pipeline.
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] ratio, input logic [CFG_W-1:0] step);
        write_cfg(REG_RATIO, ratio);
        write_cfg(REG_STEP, step);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] ratio, input logic [CFG_W-1:0] step,
                             input int mode, input bit hold, input bit pause);
        int          buf_len;
        int          pos;
        logic [15:0] smp;
        logic        is_last;
        set_regs(ratio, step);
        send_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 34 : 0;
        stall_pct     = (mode == 2) ? 53 : (mode == 3) ? 34 : 0;
        if (hold)
            hold_reqs = hold_reqs + 1;
        buf_len = $urandom_range(1, 10);
        pos     = 0;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (pause && i == PHASE_ITEMS / 2)
            begin
                s_tvalid = 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            case ($urandom_range(0, 7))
                0:       smp = 16'h7FFF;
                1:       smp = 16'h8000;
                default: smp = 16'($urandom);
            endcase
            pos     = pos + 1;
            is_last = (pos >= buf_len) || (i == PHASE_ITEMS - 1);
            send_sample(smp, is_last);
            if (is_last)
            begin
                pos     = 0;
                buf_len = $urandom_range(1, 10);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        logic [CFG_W-1:0] ph_ratio[8];
        logic [CFG_W-1:0] ph_step[8];
        logic [63:0]      rnd_ratio;

        sb            = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_RATIO;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_reqs     = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings give a straight copy; extremes of the sample range.
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        // A buffer of one sample.
        send_sample(16'h1234, 1'b1);
        wait_drained();

        // A ratio of 4.0: full-scale swings, held copies and zero padding.
        set_regs(CFG_W'(262144), CFG_W'(16384));
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_drained();

        // Smallest ratio: a one-sample buffer rounds to no output at all, and a
        // longer one reaches its count before the last sample.
        set_regs(CFG_W'(16384), CFG_W'(262144));
        send_sample(16'h0064, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0002, 1'b0);
        send_sample(16'h0003, 1'b0);
        send_sample(16'h0004, 1'b0);
        send_sample(16'h0005, 1'b1);
        wait_drained();

        // Tiny step hits the per-input cap; the backlog then interpolates at zero fraction.
        set_regs(CFG_W'(262144), CFG_W'(4096));
        send_sample(16'h03E8, 1'b0);
        send_sample(16'hFC18, 1'b0);
        send_sample(16'h01F4, 1'b0);
        send_sample(16'h0014, 1'b1);
        wait_drained();

        // Unit ratio overrides an odd step value.
        set_regs(ONE_Q16, CFG_W'(3));
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h5555, 1'b1);
        wait_drained();

        // Zero step, bounded by the cap and, on the last beat, by the buffer's output count.
        set_regs(CFG_W'(131072), CFG_W'(0));
        send_sample(16'h0007, 1'b0);
        send_sample(16'hFFF9, 1'b0);
        send_sample(16'h0009, 1'b1);
        wait_drained();

        rnd_ratio   = 64'($urandom_range(16384, 262144));
        ph_ratio[0] = ONE_Q16;              ph_step[0] = ONE_Q16;
        ph_ratio[1] = CFG_W'(98304);        ph_step[1] = CFG_W'(43691);
        ph_ratio[2] = CFG_W'(32768);        ph_step[2] = CFG_W'(131072);
        ph_ratio[3] = CFG_W'(262144);       ph_step[3] = CFG_W'(16384);
        ph_ratio[4] = CFG_W'(16384);        ph_step[4] = CFG_W'(262144);
        ph_ratio[5] = CFG_W'(rnd_ratio);
        ph_step[5]  = CFG_W'(64'h1_0000_0000 / rnd_ratio);
        ph_ratio[6] = CFG_W'($urandom_range(16384, 524287));
        ph_step[6]  = CFG_W'($urandom_range(0, 524287));
        ph_ratio[7] = CFG_W'(196608);       ph_step[7] = CFG_W'(21845);

        for (int p = 0; p < 8; p++)
            run_phase(ph_ratio[p], ph_step[p], p % 4, p == 0, p == 5);

        if (sb.pending() != 0)
            sb.note_failure($sformatf("%0d expected beats never arrived", sb.pending()));

        $display("Run covered %0d input beats in %0d buffers, %0d output beats checked,",
                 sb.inputs, sb.buffers, sb.results);
        $display("%0d register writes, four idle patterns and one long output hold-off.",
                 sb.writes);
        if (sb.errors == 0)
            $display("linear_interp_resampler: match");
        else
            $display("linear_interp_resampler: mismatch");
        $finish;
    end

endmodule
